FILE: rtl/cpuex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpuex_pkg: shared types and operation codes
// Operation numbering and flag positions for the 8-bit CPU execute unit.
// ----------------------------------------------------------------------------
package cpuex_pkg;

  typedef enum logic [5:0] {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
    OP_STX = 6'd4,  OP_STY = 6'd5,  OP_ORA = 6'd6,  OP_AND = 6'd7,
    OP_EOR = 6'd8,  OP_ADC = 6'd9,  OP_SBC = 6'd10, OP_CMP = 6'd11,
    OP_CPX = 6'd12, OP_CPY = 6'd13, OP_BIT = 6'd14, OP_ASL = 6'd15,
    OP_LSR = 6'd16, OP_ROL = 6'd17, OP_ROR = 6'd18, OP_INC = 6'd19,
    OP_DEC = 6'd20, OP_INX = 6'd21, OP_INY = 6'd22, OP_DEX = 6'd23,
    OP_DEY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
    OP_TYA = 6'd28, OP_CLC = 6'd29, OP_SEC = 6'd30, OP_CLI = 6'd31,
    OP_SEI = 6'd32, OP_CLD = 6'd33, OP_SED = 6'd34, OP_CLV = 6'd35,
    OP_PHA = 6'd36, OP_PLA = 6'd37, OP_PHP = 6'd38, OP_PLP = 6'd39,
    OP_BPL = 6'd40, OP_BMI = 6'd41, OP_BVC = 6'd42, OP_BVS = 6'd43,
    OP_BCC = 6'd44, OP_BCS = 6'd45, OP_BNE = 6'd46, OP_BEQ = 6'd47
  } op_t;

  localparam int FC = 0;
  localparam int FZ = 1;
  localparam int FI = 2;
  localparam int FD = 3;
  localparam int FB = 4;
  localparam int FU = 5;
  localparam int FV = 6;
  localparam int FN = 7;

  localparam logic [7:0] STATUS_RESET = 8'h24;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0] wdata;
    logic       wen;
    logic       taken;
  } side_t;

endpackage

FILE: rtl/cpuex_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpuex_alu: single-pass operation logic
// Computes next A, X, Y, P plus store data and branch outcome for one request.
// ----------------------------------------------------------------------------
module cpuex_alu (
  input  logic [5:0]       mode,
  input  logic [7:0]       operand,
  input  logic             to_memory,
  input  cpuex_pkg::regs_t cur,
  output cpuex_pkg::regs_t nxt,
  output cpuex_pkg::side_t side
);

  logic [7:0] m_add;
  logic [8:0] sum;
  logic [8:0] diff_src;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_in;
  logic [7:0] sh_out;
  logic       sh_c;
  logic [7:0] nz_val;
  logic       nz_en;

  always_comb begin
    m_add  = (mode == cpuex_pkg::OP_SBC) ? ~operand : operand;
    sum    = {1'b0, cur.a} + {1'b0, m_add} + {8'd0, cur.p[cpuex_pkg::FC]};
    case (mode)
      cpuex_pkg::OP_CPX: cmp_reg = cur.x;
      cpuex_pkg::OP_CPY: cmp_reg = cur.y;
      default:           cmp_reg = cur.a;
    endcase
    diff_src = {1'b0, cmp_reg};
    cmp_diff = diff_src - {1'b0, operand};
    sh_in  = to_memory ? operand : cur.a;
    case (mode)
      cpuex_pkg::OP_ASL: begin sh_out = {sh_in[6:0], 1'b0}; sh_c = sh_in[7]; end
      cpuex_pkg::OP_LSR: begin sh_out = {1'b0, sh_in[7:1]}; sh_c = sh_in[0]; end
      cpuex_pkg::OP_ROL: begin
        sh_out = {sh_in[6:0], cur.p[cpuex_pkg::FC]}; sh_c = sh_in[7];
      end
      default: begin sh_out = {cur.p[cpuex_pkg::FC], sh_in[7:1]}; sh_c = sh_in[0]; end
    endcase

    nxt    = cur;
    side   = '0;
    nz_val = 8'd0;
    nz_en  = 1'b0;
    case (mode)
      cpuex_pkg::OP_LDA, cpuex_pkg::OP_PLA: begin
        nxt.a = operand; nz_val = operand; nz_en = 1'b1;
      end
      cpuex_pkg::OP_LDX: begin nxt.x = operand; nz_val = operand; nz_en = 1'b1; end
      cpuex_pkg::OP_LDY: begin nxt.y = operand; nz_val = operand; nz_en = 1'b1; end
      cpuex_pkg::OP_STA, cpuex_pkg::OP_PHA: begin side.wdata = cur.a; side.wen = 1'b1; end
      cpuex_pkg::OP_STX: begin side.wdata = cur.x; side.wen = 1'b1; end
      cpuex_pkg::OP_STY: begin side.wdata = cur.y; side.wen = 1'b1; end
      cpuex_pkg::OP_ORA: begin nxt.a = cur.a | operand; nz_val = nxt.a; nz_en = 1'b1; end
      cpuex_pkg::OP_AND: begin nxt.a = cur.a & operand; nz_val = nxt.a; nz_en = 1'b1; end
      cpuex_pkg::OP_EOR: begin nxt.a = cur.a ^ operand; nz_val = nxt.a; nz_en = 1'b1; end
      cpuex_pkg::OP_ADC, cpuex_pkg::OP_SBC: begin
        nxt.a = sum[7:0];
        nxt.p[cpuex_pkg::FC] = sum[8];
        nxt.p[cpuex_pkg::FV] = ~(cur.a[7] ^ m_add[7]) & (cur.a[7] ^ sum[7]);
        nz_val = sum[7:0]; nz_en = 1'b1;
      end
      cpuex_pkg::OP_CMP, cpuex_pkg::OP_CPX, cpuex_pkg::OP_CPY: begin
        nxt.p[cpuex_pkg::FC] = ~cmp_diff[8];
        nz_val = cmp_diff[7:0]; nz_en = 1'b1;
      end
      cpuex_pkg::OP_BIT: begin
        nxt.p[cpuex_pkg::FZ] = ((cur.a & operand) == 8'd0);
        nxt.p[cpuex_pkg::FN] = operand[7];
        nxt.p[cpuex_pkg::FV] = operand[6];
      end
      cpuex_pkg::OP_ASL, cpuex_pkg::OP_LSR, cpuex_pkg::OP_ROL, cpuex_pkg::OP_ROR: begin
        nxt.p[cpuex_pkg::FC] = sh_c;
        nz_val = sh_out; nz_en = 1'b1;
        if (to_memory) begin
          side.wdata = sh_out; side.wen = 1'b1;
        end else begin
          nxt.a = sh_out;
        end
      end
      cpuex_pkg::OP_INC: begin
        side.wdata = operand + 8'd1; side.wen = 1'b1; nz_val = side.wdata; nz_en = 1'b1;
      end
      cpuex_pkg::OP_DEC: begin
        side.wdata = operand - 8'd1; side.wen = 1'b1; nz_val = side.wdata; nz_en = 1'b1;
      end
      cpuex_pkg::OP_INX: begin nxt.x = cur.x + 8'd1; nz_val = nxt.x; nz_en = 1'b1; end
      cpuex_pkg::OP_INY: begin nxt.y = cur.y + 8'd1; nz_val = nxt.y; nz_en = 1'b1; end
      cpuex_pkg::OP_DEX: begin nxt.x = cur.x - 8'd1; nz_val = nxt.x; nz_en = 1'b1; end
      cpuex_pkg::OP_DEY: begin nxt.y = cur.y - 8'd1; nz_val = nxt.y; nz_en = 1'b1; end
      cpuex_pkg::OP_TAX: begin nxt.x = cur.a; nz_val = cur.a; nz_en = 1'b1; end
      cpuex_pkg::OP_TAY: begin nxt.y = cur.a; nz_val = cur.a; nz_en = 1'b1; end
      cpuex_pkg::OP_TXA: begin nxt.a = cur.x; nz_val = cur.x; nz_en = 1'b1; end
      cpuex_pkg::OP_TYA: begin nxt.a = cur.y; nz_val = cur.y; nz_en = 1'b1; end
      cpuex_pkg::OP_CLC: nxt.p[cpuex_pkg::FC] = 1'b0;
      cpuex_pkg::OP_SEC: nxt.p[cpuex_pkg::FC] = 1'b1;
      cpuex_pkg::OP_CLI: nxt.p[cpuex_pkg::FI] = 1'b0;
      cpuex_pkg::OP_SEI: nxt.p[cpuex_pkg::FI] = 1'b1;
      cpuex_pkg::OP_CLD: nxt.p[cpuex_pkg::FD] = 1'b0;
      cpuex_pkg::OP_SED: nxt.p[cpuex_pkg::FD] = 1'b1;
      cpuex_pkg::OP_CLV: nxt.p[cpuex_pkg::FV] = 1'b0;
      cpuex_pkg::OP_PHP: begin
        side.wdata = cur.p;
        side.wdata[cpuex_pkg::FB] = 1'b1;
        side.wdata[cpuex_pkg::FU] = 1'b1;
        side.wen = 1'b1;
      end
      cpuex_pkg::OP_PLP: begin
        nxt.p = operand;
        nxt.p[cpuex_pkg::FB] = 1'b0;
        nxt.p[cpuex_pkg::FU] = 1'b1;
      end
      cpuex_pkg::OP_BPL: side.taken = ~cur.p[cpuex_pkg::FN];
      cpuex_pkg::OP_BMI: side.taken =  cur.p[cpuex_pkg::FN];
      cpuex_pkg::OP_BVC: side.taken = ~cur.p[cpuex_pkg::FV];
      cpuex_pkg::OP_BVS: side.taken =  cur.p[cpuex_pkg::FV];
      cpuex_pkg::OP_BCC: side.taken = ~cur.p[cpuex_pkg::FC];
      cpuex_pkg::OP_BCS: side.taken =  cur.p[cpuex_pkg::FC];
      cpuex_pkg::OP_BNE: side.taken = ~cur.p[cpuex_pkg::FZ];
      cpuex_pkg::OP_BEQ: side.taken =  cur.p[cpuex_pkg::FZ];
      default: ;
    endcase
    if (nz_en) begin
      nxt.p[cpuex_pkg::FN] = nz_val[7];
      nxt.p[cpuex_pkg::FZ] = (nz_val == 8'd0);
    end
  end

endmodule

FILE: rtl/eight_bit_cpu_execute_unit_core.sv
`timescale 1ns / 1ps
// Result: the outcome of an accepted request is captured in the result register.
// Throughput: one request per cycle unless stalled; the architectural registers are
// updated at acceptance, so the next request sees them directly.
// Stall: a full result register with out_tready low holds in_tready low.
// Reset: A, X, Y cleared, status 0x24, result register empty.
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit_core: 8-bit CPU execute unit top level
// Register file plus result register around the single-pass ALU.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // mode[5:0], operand[13:6], to_memory[14], zero[15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // write_data, write_enable, branch_taken, acc,
                                  // index_x, index_y, status, zero pad[47:42]
);

  cpuex_pkg::regs_t regs_r;
  cpuex_pkg::regs_t regs_nxt;
  cpuex_pkg::side_t side;
  logic             acc_in;
  logic             vld_r;
  logic [41:0]      res_r;

  cpuex_alu u_alu (
    .mode      (in_tdata[5:0]),
    .operand   (in_tdata[13:6]),
    .to_memory (in_tdata[14]),
    .cur       (regs_r),
    .nxt       (regs_nxt),
    .side      (side)
  );

  assign in_tready = ~vld_r | out_tready;
  assign acc_in    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r   <= {24'd0, cpuex_pkg::STATUS_RESET};
      vld_r    <= 1'b0;
    end else begin
      if (acc_in) begin
        regs_r <= regs_nxt;
      end
      if (in_tready) begin
        vld_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      res_r <= {regs_nxt.p, regs_nxt.y, regs_nxt.x, regs_nxt.a,
                side.taken, side.wen, side.wdata};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'd0, res_r};

endmodule

FILE: bench/eight_bit_cpu_execute_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit_core_tb: execute unit stream checker
// Sends decoded operations with operands through the request stream, keeps a
// shadow of A, X, Y and the status byte, and checks every returned result
// against the shadow's outcome. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit_core_tb;

  typedef struct packed {
    logic       to_mem;
    logic [7:0] operand;
    logic [5:0] mode;
  } request_t;

  typedef struct packed {
    logic [7:0] p;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] a;
    logic       taken;
    logic       wen;
    logic [7:0] wdata;
  } outcome_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1550;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  logic [7:0] sh_a, sh_x, sh_y, sh_p;
  int mismatches;
  int cycles;
  bit calm;
  int send_gap;
  int take_gap;
  bit stim_done;

  eight_bit_cpu_execute_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void set_nz(input logic [7:0] v);
    sh_p[cpuex_pkg::FN] = v[7];
    sh_p[cpuex_pkg::FZ] = (v == 8'd0);
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, sh_a} + {1'b0, m} + {8'd0, sh_p[cpuex_pkg::FC]};
    sh_p[cpuex_pkg::FC] = sum[8];
    sh_p[cpuex_pkg::FV] = ~(sh_a[7] ^ m[7]) & (sh_a[7] ^ sum[7]);
    sh_a = sum[7:0];
    set_nz(sh_a);
  endfunction

  function automatic void compare(input logic [7:0] r, input logic [7:0] m);
    sh_p[cpuex_pkg::FC] = (r >= m);
    set_nz(r - m);
  endfunction

  // Advance the shadow registers by one request and return its outcome.
  function automatic outcome_t execute_op(input request_t rq);
    outcome_t o;
    logic [7:0] m, v, r;
    logic cin;
    m = rq.operand;
    o = '0;
    case (rq.mode)
      cpuex_pkg::OP_LDA, cpuex_pkg::OP_PLA: begin sh_a = m; set_nz(m); end
      cpuex_pkg::OP_LDX: begin sh_x = m; set_nz(m); end
      cpuex_pkg::OP_LDY: begin sh_y = m; set_nz(m); end
      cpuex_pkg::OP_STA, cpuex_pkg::OP_PHA: begin o.wdata = sh_a; o.wen = 1'b1; end
      cpuex_pkg::OP_STX: begin o.wdata = sh_x; o.wen = 1'b1; end
      cpuex_pkg::OP_STY: begin o.wdata = sh_y; o.wen = 1'b1; end
      cpuex_pkg::OP_ORA: begin sh_a = sh_a | m; set_nz(sh_a); end
      cpuex_pkg::OP_AND: begin sh_a = sh_a & m; set_nz(sh_a); end
      cpuex_pkg::OP_EOR: begin sh_a = sh_a ^ m; set_nz(sh_a); end
      cpuex_pkg::OP_ADC: add_carry(m);
      cpuex_pkg::OP_SBC: add_carry(~m);
      cpuex_pkg::OP_CMP: compare(sh_a, m);
      cpuex_pkg::OP_CPX: compare(sh_x, m);
      cpuex_pkg::OP_CPY: compare(sh_y, m);
      cpuex_pkg::OP_BIT: begin
        sh_p[cpuex_pkg::FZ] = ((sh_a & m) == 8'd0);
        sh_p[cpuex_pkg::FN] = m[7];
        sh_p[cpuex_pkg::FV] = m[6];
      end
      cpuex_pkg::OP_ASL, cpuex_pkg::OP_LSR, cpuex_pkg::OP_ROL, cpuex_pkg::OP_ROR: begin
        v = rq.to_mem ? m : sh_a;
        cin = sh_p[cpuex_pkg::FC];
        case (rq.mode)
          cpuex_pkg::OP_ASL: begin r = {v[6:0], 1'b0}; sh_p[cpuex_pkg::FC] = v[7]; end
          cpuex_pkg::OP_LSR: begin r = {1'b0, v[7:1]}; sh_p[cpuex_pkg::FC] = v[0]; end
          cpuex_pkg::OP_ROL: begin r = {v[6:0], cin}; sh_p[cpuex_pkg::FC] = v[7]; end
          default: begin r = {cin, v[7:1]}; sh_p[cpuex_pkg::FC] = v[0]; end
        endcase
        set_nz(r);
        if (rq.to_mem) begin
          o.wdata = r;
          o.wen = 1'b1;
        end else begin
          sh_a = r;
        end
      end
      cpuex_pkg::OP_INC: begin o.wdata = m + 8'd1; o.wen = 1'b1; set_nz(o.wdata); end
      cpuex_pkg::OP_DEC: begin o.wdata = m - 8'd1; o.wen = 1'b1; set_nz(o.wdata); end
      cpuex_pkg::OP_INX: begin sh_x = sh_x + 8'd1; set_nz(sh_x); end
      cpuex_pkg::OP_INY: begin sh_y = sh_y + 8'd1; set_nz(sh_y); end
      cpuex_pkg::OP_DEX: begin sh_x = sh_x - 8'd1; set_nz(sh_x); end
      cpuex_pkg::OP_DEY: begin sh_y = sh_y - 8'd1; set_nz(sh_y); end
      cpuex_pkg::OP_TAX: begin sh_x = sh_a; set_nz(sh_a); end
      cpuex_pkg::OP_TAY: begin sh_y = sh_a; set_nz(sh_a); end
      cpuex_pkg::OP_TXA: begin sh_a = sh_x; set_nz(sh_a); end
      cpuex_pkg::OP_TYA: begin sh_a = sh_y; set_nz(sh_a); end
      cpuex_pkg::OP_CLC: sh_p[cpuex_pkg::FC] = 1'b0;
      cpuex_pkg::OP_SEC: sh_p[cpuex_pkg::FC] = 1'b1;
      cpuex_pkg::OP_CLI: sh_p[cpuex_pkg::FI] = 1'b0;
      cpuex_pkg::OP_SEI: sh_p[cpuex_pkg::FI] = 1'b1;
      cpuex_pkg::OP_CLD: sh_p[cpuex_pkg::FD] = 1'b0;
      cpuex_pkg::OP_SED: sh_p[cpuex_pkg::FD] = 1'b1;
      cpuex_pkg::OP_CLV: sh_p[cpuex_pkg::FV] = 1'b0;
      cpuex_pkg::OP_PHP: begin
        o.wdata = sh_p;
        o.wdata[cpuex_pkg::FB] = 1'b1;
        o.wdata[cpuex_pkg::FU] = 1'b1;
        o.wen = 1'b1;
      end
      cpuex_pkg::OP_PLP: begin
        sh_p = m;
        sh_p[cpuex_pkg::FU] = 1'b1;
        sh_p[cpuex_pkg::FB] = 1'b0;
      end
      cpuex_pkg::OP_BPL: o.taken = ~sh_p[cpuex_pkg::FN];
      cpuex_pkg::OP_BMI: o.taken = sh_p[cpuex_pkg::FN];
      cpuex_pkg::OP_BVC: o.taken = ~sh_p[cpuex_pkg::FV];
      cpuex_pkg::OP_BVS: o.taken = sh_p[cpuex_pkg::FV];
      cpuex_pkg::OP_BCC: o.taken = ~sh_p[cpuex_pkg::FC];
      cpuex_pkg::OP_BCS: o.taken = sh_p[cpuex_pkg::FC];
      cpuex_pkg::OP_BNE: o.taken = ~sh_p[cpuex_pkg::FZ];
      cpuex_pkg::OP_BEQ: o.taken = sh_p[cpuex_pkg::FZ];
      default: ;
    endcase
    o.a = sh_a;
    o.x = sh_x;
    o.y = sh_y;
    o.p = sh_p;
    return o;
  endfunction

  task automatic queue_op(input logic [5:0] mode, input logic [7:0] operand,
                          input logic to_mem);
    request_t rq;
    rq.mode = mode;
    rq.operand = operand;
    rq.to_mem = to_mem;
    pending_requests.push_back(rq);
  endtask

  initial begin
    int pick;
    logic [5:0] md;
    mismatches = 0;
    sh_a = 8'd0;
    sh_x = 8'd0;
    sh_y = 8'd0;
    sh_p = cpuex_pkg::STATUS_RESET;
    // Directed: extremes, overflow corners, push/pull status, unused code.
    queue_op(cpuex_pkg::OP_LDA, 8'h00, 1'b0);
    queue_op(cpuex_pkg::OP_LDX, 8'hFF, 1'b1);
    queue_op(cpuex_pkg::OP_LDY, 8'h80, 1'b0);
    queue_op(cpuex_pkg::OP_LDA, 8'h7F, 1'b0);
    queue_op(cpuex_pkg::OP_ADC, 8'h01, 1'b0);
    queue_op(cpuex_pkg::OP_SBC, 8'h01, 1'b1);
    queue_op(cpuex_pkg::OP_SBC, 8'h80, 1'b0);
    queue_op(cpuex_pkg::OP_ADC, 8'hFF, 1'b0);
    queue_op(cpuex_pkg::OP_PHP, 8'h00, 1'b0);
    queue_op(cpuex_pkg::OP_PLP, 8'hFF, 1'b0);
    queue_op(cpuex_pkg::OP_PHP, 8'hA5, 1'b1);
    queue_op(cpuex_pkg::OP_SED, 8'h00, 1'b0);
    queue_op(cpuex_pkg::OP_ADC, 8'h09, 1'b0);
    queue_op(cpuex_pkg::OP_PLP, 8'h00, 1'b0);
    queue_op(cpuex_pkg::OP_ROR, 8'h01, 1'b1);
    queue_op(cpuex_pkg::OP_ROL, 8'h80, 1'b0);
    queue_op(cpuex_pkg::OP_DEC, 8'h00, 1'b0);
    queue_op(cpuex_pkg::OP_INC, 8'hFF, 1'b0);
    queue_op(cpuex_pkg::OP_BEQ, 8'hFF, 1'b0);
    queue_op(cpuex_pkg::OP_BNE, 8'h80, 1'b1);
    queue_op(6'd48, 8'hFF, 1'b1);
    queue_op(6'd63, 8'h00, 1'b0);
    for (int op = 0; op < 48; op++) begin
      queue_op(op[5:0], 8'($urandom), 1'($urandom));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        md = 6'($urandom_range(48, 63));
      end else if (pick < 12) begin
        md = cpuex_pkg::OP_PLP;
      end else begin
        md = 6'($urandom_range(0, 47));
      end
      pick = $urandom_range(0, 9);
      queue_op(md, pick < 2 ? 8'h00 : pick < 4 ? 8'hFF : pick < 5 ? 8'h80 : 8'($urandom),
               1'($urandom));
    end
    stim_done = 1'b1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Last part of the run goes without idling.
  always @(posedge clk) begin
    calm <= (pending_requests.size() < 200);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_outcomes.push_back(execute_op(pending_requests.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until taken
      end else if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_requests.size() > 0) begin
        if (!calm && $urandom_range(0, 19) == 0) begin
          in_tvalid <= 1'b0;
          send_gap <= $urandom_range(0, 14);
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, pending_requests[0]};
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: wd %h/%h we %b/%b br %b/%b a %h/%h x %h/%h y %h/%h p %h/%h",
                       want.wdata, got.wdata, want.wen, got.wen, want.taken, got.taken,
                       want.a, got.a, want.x, got.x, want.y, got.y, want.p, got.p);
            end
          end
        end
      end
      if (take_gap > 0) begin
        out_tready <= 1'b0;
        take_gap <= take_gap - 1;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        out_tready <= 1'b0;
        take_gap <= $urandom_range(0, 14);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    take_gap = 0;
    @(posedge clk);
    while (!(stim_done && pending_requests.size() == 0 && !in_tvalid
             && expected_outcomes.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("eight_bit_cpu_execute_unit_core_tb: FAIL");
    end else begin
      repeat (5) @(posedge clk);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
        $display("eight_bit_cpu_execute_unit_core_tb: PASS");
      end else begin
        $display("eight_bit_cpu_execute_unit_core_tb: FAIL");
      end
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cpuex_pkg.sv
rtl/cpuex_alu.sv
rtl/eight_bit_cpu_execute_unit_core.sv
bench/eight_bit_cpu_execute_unit_core_tb.sv
